FILE: hw/rtl/shs_pkg.sv
// shs_pkg: shared types, constants and helpers of the successive-halving scheduler
// depends on nothing; imported by shs_div, shs_cell and successive_halving_scheduler
package shs_pkg;

  localparam int KIND_W      = 2;
  localparam int ID_W        = 32;
  localparam int BUD_W       = 16;
  localparam int SCORE_W     = 32;
  localparam int SPENT_W     = 48;
  localparam int RUNG_W      = 4;
  localparam int BRK_W       = 4;
  localparam int ETA_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_W       = 37;
  localparam int DEN_W       = 32;
  localparam int PROD_W      = 20;
  localparam int MAX_LIST    = 64;
  localparam int CAPACITY_DEF = 64;
  localparam int TOP_LIMIT   = 15;

  localparam int ETA_RST  = 3;
  localparam int MINB_RST = 1;
  localparam int MAXB_RST = 27;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic [SPENT_W-1:0] SPENT_MAX = {SPENT_W{1'b1}};

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ASK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TELL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ETA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINB = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXB = 2'd2;

  // one slot of the candidate row
  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
    logic                      scored;
    logic                      alive;
  } slot_t;

  typedef enum logic [2:0] {
    COP_HOLD  = 3'd0,
    COP_SHIFT = 3'd1,
    COP_PINIT = 3'd2,
    COP_RANK  = 3'd3,
    COP_MARK  = 3'd4,
    COP_PACK  = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
  } cell_ctl_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  // highest bracket index for given settings, elaboration use only
  function automatic logic [BRK_W-1:0] top_of(input int e, input int mn, input int mx);
    int v;
    int s;
    v = mn;
    s = 0;
    for (int k = 0; k < TOP_LIMIT; k++) begin
      if (v * e <= mx) begin
        v = v * e;
        s = s + 1;
      end
    end
    return BRK_W'(s);
  endfunction

  localparam logic [BRK_W-1:0] TOP_RST = top_of(ETA_RST, MINB_RST, MAXB_RST);

endpackage

FILE: hw/rtl/shs_div.sv
// shs_div: restoring divider, one quotient bit per cycle
// depends on shs_pkg (request and response structs, widths)
module shs_div (
  input  logic             clk,
  input  logic             rst_n,
  input  shs_pkg::div_req_t req,
  output shs_pkg::div_rsp_t rsp
);
  import shs_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quot_r;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // trial subtract of the next partial remainder
  always_comb begin
    trial = {rem_r, quot_r[NUM_W-1]};
    qbit  = (trial >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      den_r  <= req.denom;
      quot_r <= req.numer;
    end else if (busy_r) begin
      if (qbit) begin
        rem_r <= DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem_r <= trial[DEN_W-1:0];
      end
      quot_r <= {quot_r[NUM_W-2:0], qbit};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

FILE: hw/rtl/shs_cell.sv
// shs_cell: one slot of the candidate row with its rank counter and probe stage
// depends on shs_pkg (slot_t, cell_ctl_t)
module shs_cell #(
  parameter int CAPACITY = shs_pkg::CAPACITY_DEF,
  parameter int POS      = 0
) (
  input  logic                          clk,
  input  shs_pkg::cell_ctl_t            ctl,
  input  logic [$clog2(CAPACITY+1)-1:0] n_i,
  input  logic [$clog2(CAPACITY+1)-1:0] keep_i,
  input  shs_pkg::slot_t                right_i,
  input  shs_pkg::slot_t                left_i,
  input  shs_pkg::slot_t                probe_right_i,
  input  logic [$clog2(CAPACITY)-1:0]   probe_orig_right_i,
  output shs_pkg::slot_t                entry_o,
  output shs_pkg::slot_t                probe_o,
  output logic [$clog2(CAPACITY)-1:0]   probe_orig_o
);
  import shs_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] POS_I = IW'(POS);
  localparam logic [CW-1:0] POS_C = CW'(POS);
  localparam logic HAS_R = (POS < CAPACITY - 1);
  localparam logic HAS_L = (POS > 0);
  localparam logic R_PAR = 1'(POS % 2);
  localparam logic L_PAR = 1'((POS + 1) % 2);

  slot_t         entry_r;
  slot_t         probe_r;
  logic [IW-1:0] porig_r;
  logic [IW-1:0] rank_r;
  logic          probe_beats;
  logic          own_beats;
  logic          rank_inc;

  // pairwise order: scored before unscored, then higher score, ties to lower index
  always_comb begin
    if (probe_r.scored != entry_r.scored) begin
      probe_beats = probe_r.scored;
      own_beats   = entry_r.scored;
    end else begin
      probe_beats = (probe_r.score > entry_r.score);
      own_beats   = (entry_r.score > probe_r.score);
    end
    rank_inc = (CW'(porig_r) < n_i) && (porig_r != POS_I) &&
               (probe_beats || ((porig_r < POS_I) && !own_beats));
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      COP_HOLD: begin
      end
      COP_SHIFT: begin
        entry_r <= right_i;
      end
      COP_PINIT: begin
        probe_r <= entry_r;
        porig_r <= POS_I;
        rank_r  <= '0;
      end
      COP_RANK: begin
        if (rank_inc) begin
          rank_r <= rank_r + IW'(1);
        end
        probe_r <= probe_right_i;
        porig_r <= probe_orig_right_i;
      end
      COP_MARK: begin
        entry_r.alive <= (POS_C < n_i) && (CW'(rank_r) < keep_i);
      end
      COP_PACK: begin
        // odd-even exchange moves survivors toward the head, order kept
        if (HAS_R && (ctl.phase == R_PAR) && !entry_r.alive && right_i.alive) begin
          entry_r <= right_i;
        end else if (HAS_L && (ctl.phase == L_PAR) && !left_i.alive && entry_r.alive) begin
          entry_r <= left_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign entry_o      = entry_r;
  assign probe_o      = probe_r;
  assign probe_orig_o = porig_r;

endmodule

FILE: hw/rtl/successive_halving_scheduler.sv
// successive_halving_scheduler: top level, sequencer, registers and the row of slot cells
// depends on shs_pkg, shs_div and shs_cell
// ask: a bracket start takes up to 15 power steps and two divisions, then fills the row;
//   listing is one rotation of the row, one item out per cycle while out_stall is low
// tell: one rotation of the row searches by id; a batch end adds a division
//   and, when candidates survive, ranking, marking and packing
// one request at a time; a reset request adds a top bracket search; rst_n resets control state
module successive_halving_scheduler #(
  parameter int CAPACITY = shs_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [shs_pkg::KIND_W-1:0]           in_kind,
  input  logic [shs_pkg::ID_W-1:0]             in_candidate_id,
  input  logic [shs_pkg::BUD_W-1:0]            in_budget_used,
  input  logic signed [shs_pkg::SCORE_W-1:0]   in_score,
  input  logic                                 in_batch_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [shs_pkg::ID_W-1:0]             out_id,
  output logic [shs_pkg::BUD_W-1:0]            out_budget,
  output logic [shs_pkg::RUNG_W-1:0]           out_rung,
  output logic                                 out_final_item,
  output logic signed [shs_pkg::SCORE_W-1:0]   out_best_score,
  output logic [shs_pkg::ID_W-1:0]             out_best_id,
  output logic [shs_pkg::SPENT_W-1:0]          out_spent_total,
  input  logic                                 cfg_wr_en,
  input  logic [shs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [shs_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import shs_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LIST_N = (CAPACITY < MAX_LIST) ? CAPACITY : MAX_LIST;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_TOPB  = 13'b0000000000010,
    ST_POW   = 13'b0000000000100,
    ST_DIVN  = 13'b0000000001000,
    ST_DIVB  = 13'b0000000010000,
    ST_FILL  = 13'b0000000100000,
    ST_LIST  = 13'b0000001000000,
    ST_SRCH  = 13'b0000010000000,
    ST_DIVK  = 13'b0000100000000,
    ST_PINIT = 13'b0001000000000,
    ST_RANK  = 13'b0010000000000,
    ST_MARK  = 13'b0100000000000,
    ST_PACK  = 13'b1000000000000
  } st_t;

  st_t                      state_r;
  logic [CW-1:0]            t_r;
  logic [CW-1:0]            act_r;
  logic [CW-1:0]            n_r;
  logic [BRK_W-1:0]         brk_r;
  logic [BRK_W-1:0]         top_r;
  logic [RUNG_W-1:0]        rung_r;
  logic [BUD_W-1:0]         rbud_r;
  logic [ID_W-1:0]          serial_r;
  logic signed [SCORE_W-1:0] best_s_r;
  logic [ID_W-1:0]          best_id_r;
  logic [SPENT_W-1:0]       spent_r;
  logic [DEN_W-1:0]         pow_r;
  logic [BRK_W-1:0]         pcnt_r;
  logic [BUD_W-1:0]         tv_r;
  logic [BRK_W-1:0]         tcnt_r;
  logic [ID_W-1:0]          req_id_r;
  logic signed [SCORE_W-1:0] req_sc_r;
  logic                     req_end_r;
  logic                     found_r;
  logic [ETA_W-1:0]         eta_r;
  logic [BUD_W-1:0]         minb_r;
  logic [BUD_W-1:0]         maxb_r;
  div_req_t                 div_req_r;

  logic                     out_valid_r;
  logic [ID_W-1:0]          out_id_r;
  logic [BUD_W-1:0]         out_bud_r;
  logic [RUNG_W-1:0]        out_rung_r;
  logic                     out_final_r;
  logic signed [SCORE_W-1:0] out_bs_r;
  logic [ID_W-1:0]          out_bi_r;
  logic [SPENT_W-1:0]       out_sp_r;

  div_rsp_t                 div_rsp;
  cell_ctl_t                cell_ctl;
  slot_t                    tail_w;
  slot_t                    head_w;
  slot_t                    entry_w [CAPACITY];
  slot_t                    probe_w [CAPACITY];
  logic [IW-1:0]            porig_w [CAPACITY];
  slot_t                    right_w [CAPACITY];
  slot_t                    left_w  [CAPACITY];
  slot_t                    prb_in_w [CAPACITY];
  logic [IW-1:0]            prbo_in_w [CAPACITY];

  logic [ETA_W-1:0]         eff_eta;
  logic [BUD_W-1:0]         eff_min;
  logic [SPENT_W:0]         spent_sum;
  logic [SPENT_W-1:0]       spent_nxt;
  logic [DEN_W+ETA_W-1:0]   pow_prod;
  logic [DEN_W-1:0]         pow_nxt;
  logic [PROD_W-1:0]        tv_prod;
  logic [PROD_W-1:0]        nb_prod;
  logic [BUD_W-1:0]         rbud_nxt;
  logic [NUM_W-1:0]         cnt_numer;
  logic [CW-1:0]            nlist;
  logic                     t_last;
  logic                     out_free;
  logic                     list_adv;
  logic                     hit;

  // effective settings and arithmetic helpers
  always_comb begin
    eff_eta   = (eta_r < ETA_W'(2)) ? ETA_W'(2) : eta_r;
    eff_min   = (minb_r == '0) ? BUD_W'(1) : minb_r;
    spent_sum = {1'b0, spent_r} + (SPENT_W+1)'(in_budget_used);
    spent_nxt = spent_sum[SPENT_W] ? SPENT_MAX : spent_sum[SPENT_W-1:0];
    pow_prod  = pow_r * eff_eta;
    pow_nxt   = (pow_prod > (DEN_W+ETA_W)'({DEN_W{1'b1}})) ? {DEN_W{1'b1}} :
                pow_prod[DEN_W-1:0];
    tv_prod   = PROD_W'(tv_r) * PROD_W'(eff_eta);
    nb_prod   = PROD_W'(rbud_r) * PROD_W'(eff_eta);
    rbud_nxt  = (nb_prod > PROD_W'(maxb_r)) ? maxb_r : nb_prod[BUD_W-1:0];
    cnt_numer = NUM_W'((DEN_W+BRK_W+1)'({1'b0, top_r} + (BRK_W+1)'(1)) * pow_r) +
                NUM_W'(brk_r);
    nlist     = (act_r > CW'(LIST_N)) ? CW'(LIST_N) : act_r;
    t_last    = (t_r == CW'(CAPACITY - 1));
    out_free  = !out_valid_r || !out_stall;
    list_adv  = (t_r >= nlist) || out_free;
  end

  // request for the tail of the row
  assign head_w = entry_w[0];
  always_comb begin
    hit    = (t_r < act_r) && !found_r && (head_w.id == req_id_r);
    tail_w = head_w;
    if (state_r == ST_FILL && t_r < n_r) begin
      tail_w.id     = serial_r;
      tail_w.score  = SCORE_MIN;
      tail_w.scored = 1'b0;
      tail_w.alive  = 1'b0;
    end else if (state_r == ST_SRCH && hit) begin
      tail_w.score  = req_sc_r;
      tail_w.scored = 1'b1;
    end
  end

  // cell row control
  always_comb begin
    cell_ctl.phase = t_r[0];
    unique case (state_r)
      ST_FILL, ST_SRCH: cell_ctl.op = COP_SHIFT;
      ST_LIST:          cell_ctl.op = list_adv ? COP_SHIFT : COP_HOLD;
      ST_PINIT:         cell_ctl.op = COP_PINIT;
      ST_RANK:          cell_ctl.op = COP_RANK;
      ST_MARK:          cell_ctl.op = COP_MARK;
      ST_PACK:          cell_ctl.op = COP_PACK;
      default:          cell_ctl.op = COP_HOLD;
    endcase
  end

  // sequencer and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      t_r         <= '0;
      act_r       <= '0;
      n_r         <= '0;
      brk_r       <= '0;
      top_r       <= TOP_RST;
      rung_r      <= '0;
      rbud_r      <= '0;
      serial_r    <= ID_W'(1);
      best_s_r    <= SCORE_MIN;
      best_id_r   <= '0;
      spent_r     <= '0;
      found_r     <= 1'b0;
      eta_r       <= ETA_W'(ETA_RST);
      minb_r      <= BUD_W'(MINB_RST);
      maxb_r      <= BUD_W'(MAXB_RST);
      div_req_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ETA:  eta_r  <= cfg_data[ETA_W-1:0];
          CFG_MINB: minb_r <= cfg_data[BUD_W-1:0];
          CFG_MAXB: maxb_r <= cfg_data[BUD_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      div_req_r.start <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            unique case (in_kind)
              KIND_ASK: begin
                t_r <= '0;
                if (act_r == '0 && rung_r == '0) begin
                  pow_r   <= DEN_W'(1);
                  pcnt_r  <= '0;
                  state_r <= ST_POW;
                end else begin
                  state_r <= ST_LIST;
                end
              end
              KIND_TELL: begin
                spent_r <= spent_nxt;
                if (in_score > best_s_r) begin
                  best_s_r  <= in_score;
                  best_id_r <= in_candidate_id;
                end
                req_id_r  <= in_candidate_id;
                req_sc_r  <= in_score;
                req_end_r <= in_batch_end;
                found_r   <= 1'b0;
                t_r       <= '0;
                state_r   <= ST_SRCH;
              end
              KIND_RESET: begin
                act_r     <= '0;
                brk_r     <= '0;
                rung_r    <= '0;
                rbud_r    <= '0;
                serial_r  <= ID_W'(1);
                best_s_r  <= SCORE_MIN;
                best_id_r <= '0;
                spent_r   <= '0;
                tv_r      <= eff_min;
                tcnt_r    <= '0;
                state_r   <= ST_TOPB;
              end
              default: begin
              end
            endcase
          end
        end
        // top bracket search after a reset request
        ST_TOPB: begin
          if (tcnt_r < BRK_W'(TOP_LIMIT) && tv_prod <= PROD_W'(maxb_r)) begin
            tv_r   <= tv_prod[BUD_W-1:0];
            tcnt_r <= tcnt_r + BRK_W'(1);
          end else begin
            top_r   <= tcnt_r;
            state_r <= ST_IDLE;
          end
        end
        // eta to the power of the bracket index, saturating
        ST_POW: begin
          if (pcnt_r < brk_r) begin
            pow_r  <= pow_nxt;
            pcnt_r <= pcnt_r + BRK_W'(1);
          end else begin
            div_req_r.start <= 1'b1;
            div_req_r.numer <= cnt_numer;
            div_req_r.denom <= DEN_W'(brk_r) + DEN_W'(1);
            state_r         <= ST_DIVN;
          end
        end
        ST_DIVN: begin
          if (div_rsp.done) begin
            n_r <= (div_rsp.quot > NUM_W'(CAPACITY)) ? CW'(CAPACITY) :
                   div_rsp.quot[CW-1:0];
            div_req_r.start <= 1'b1;
            div_req_r.numer <= NUM_W'(maxb_r);
            div_req_r.denom <= pow_r;
            state_r         <= ST_DIVB;
          end
        end
        ST_DIVB: begin
          if (div_rsp.done) begin
            rbud_r  <= (div_rsp.quot < NUM_W'(eff_min)) ? eff_min :
                       div_rsp.quot[BUD_W-1:0];
            t_r     <= '0;
            state_r <= ST_FILL;
          end
        end
        // fresh ids shift in at the tail
        ST_FILL: begin
          t_r <= t_r + CW'(1);
          if (t_r < n_r) begin
            serial_r <= serial_r + ID_W'(1);
          end
          if (t_last) begin
            act_r   <= n_r;
            t_r     <= '0;
            state_r <= ST_LIST;
          end
        end
        // full rotation, head goes out while within the list
        ST_LIST: begin
          if (list_adv) begin
            if (t_r < nlist) begin
              out_valid_r <= 1'b1;
              out_id_r    <= head_w.id;
              out_bud_r   <= rbud_r;
              out_rung_r  <= rung_r;
              out_final_r <= ((t_r + CW'(1)) == nlist);
              out_bs_r    <= best_s_r;
              out_bi_r    <= best_id_r;
              out_sp_r    <= spent_r;
            end
            t_r <= t_r + CW'(1);
            if (t_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        // full rotation, first matching active slot takes the score
        ST_SRCH: begin
          if (hit) begin
            found_r <= 1'b1;
          end
          t_r <= t_r + CW'(1);
          if (t_last) begin
            if (req_end_r) begin
              div_req_r.start <= 1'b1;
              div_req_r.numer <= NUM_W'(act_r);
              div_req_r.denom <= DEN_W'(eff_eta);
              state_r         <= ST_DIVK;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_DIVK: begin
          if (div_rsp.done) begin
            n_r <= div_rsp.quot[CW-1:0];
            if (div_rsp.quot == '0 || rbud_r >= maxb_r) begin
              act_r   <= '0;
              rung_r  <= '0;
              brk_r   <= (brk_r == top_r) ? '0 : brk_r + BRK_W'(1);
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_PINIT;
            end
          end
        end
        ST_PINIT: begin
          t_r     <= '0;
          state_r <= ST_RANK;
        end
        ST_RANK: begin
          t_r <= t_r + CW'(1);
          if (t_last) begin
            state_r <= ST_MARK;
          end
        end
        ST_MARK: begin
          t_r     <= '0;
          state_r <= ST_PACK;
        end
        ST_PACK: begin
          t_r <= t_r + CW'(1);
          if (t_last) begin
            act_r   <= n_r;
            rbud_r  <= rbud_nxt;
            rung_r  <= rung_r + RUNG_W'(1);
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // shared divider
  shs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req_r),
    .rsp  (div_rsp)
  );

  // row of slot cells, entries move toward the head, probes rotate the same way
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w[g]   = tail_w;
      assign prb_in_w[g]  = probe_w[0];
      assign prbo_in_w[g] = porig_w[0];
    end else begin : g_mid
      assign right_w[g]   = entry_w[g+1];
      assign prb_in_w[g]  = probe_w[g+1];
      assign prbo_in_w[g] = porig_w[g+1];
    end
    if (g == 0) begin : g_head
      assign left_w[g] = entry_w[CAPACITY-1];
    end else begin : g_body
      assign left_w[g] = entry_w[g-1];
    end

    shs_cell #(
      .CAPACITY(CAPACITY),
      .POS     (g)
    ) u_cell (
      .clk               (clk),
      .ctl               (cell_ctl),
      .n_i               (act_r),
      .keep_i            (n_r),
      .right_i           (right_w[g]),
      .left_i            (left_w[g]),
      .probe_right_i     (prb_in_w[g]),
      .probe_orig_right_i(prbo_in_w[g]),
      .entry_o           (entry_w[g]),
      .probe_o           (probe_w[g]),
      .probe_orig_o      (porig_w[g])
    );
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_id          = out_id_r;
  assign out_budget      = out_bud_r;
  assign out_rung        = out_rung_r;
  assign out_final_item  = out_final_r;
  assign out_best_score  = out_bs_r;
  assign out_best_id     = out_bi_r;
  assign out_spent_total = out_sp_r;

  // a new result only comes from the listing rotation
  a_out_from_list: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_LIST)
    else $error("result raised outside listing");

  // active count never exceeds the row
  a_act_bound: assert property (@(posedge clk) disable iff (!rst_n)
    act_r <= CW'(CAPACITY))
    else $error("active count beyond capacity");

  // current bracket stays within the bracket range
  a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    brk_r <= top_r)
    else $error("bracket index beyond top bracket");

  // input held off while the divider works
  a_div_stall: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> in_stall)
    else $error("request accepted during division");

endmodule

FILE: dv/successive_halving_scheduler_tb.sv
// successive_halving_scheduler_tb: self-checking bench for the successive-halving scheduler
// depends on shs_pkg and successive_halving_scheduler; a bracket tracker class predicts listings
`timescale 1ns / 100ps

module successive_halving_scheduler_tb;
  import shs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 480;

  typedef struct {
    logic [ID_W-1:0]           id;
    logic [BUD_W-1:0]          budget;
    logic [RUNG_W-1:0]         rung;
    logic                      final_item;
    logic signed [SCORE_W-1:0] best_score;
    logic [ID_W-1:0]           best_id;
    logic [SPENT_W-1:0]        spent;
  } listing_t;

  // tracks bracket state and the listings each ask should produce
  class bracket_tracker;
    bit [3:0]                 eta_r;
    bit [15:0]                minb_r;
    bit [15:0]                maxb_r;
    bit [31:0]                ids[64];
    bit signed [31:0]         scs[64];
    bit                       scd[64];
    int unsigned              count;
    int unsigned              brk;
    int unsigned              top;
    int unsigned              rung;
    longint unsigned          rbud;
    bit [31:0]                serial;
    bit signed [31:0]         best_sc;
    bit [31:0]                best_id;
    longint unsigned          spent;
    listing_t                 listings_q[$];
    int                       errors;

    function new();
      eta_r = 4'(ETA_RST);
      minb_r = 16'(MINB_RST);
      maxb_r = 16'(MAXB_RST);
      errors = 0;
      clear();
    endfunction

    function longint unsigned eff_eta();
      return (eta_r < 2) ? 2 : eta_r;
    endfunction

    function longint unsigned eff_min();
      return (minb_r == 0) ? 1 : minb_r;
    endfunction

    function void clear();
      longint unsigned v;
      count = 0;
      brk = 0;
      rung = 0;
      rbud = 0;
      serial = 1;
      best_sc = SCORE_MIN;
      best_id = 0;
      spent = 0;
      v = eff_min();
      top = 0;
      while (top < TOP_LIMIT && v * eff_eta() <= maxb_r) begin
        v = v * eff_eta();
        top++;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ETA:  eta_r = val[3:0];
        CFG_MINB: minb_r = val;
        CFG_MAXB: maxb_r = val;
        default: ;
      endcase
    endfunction

    // fresh candidates for the current bracket
    function void open_bracket();
      longint unsigned p, n, b;
      p = 1;
      for (int i = 0; i < brk; i++) begin
        p = p * eff_eta();
        if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      end
      n = ((top + 1) * p + brk) / (brk + 1);
      if (n > 64) n = 64;
      b = maxb_r / p;
      if (b < eff_min()) b = eff_min();
      rbud = b & 16'hFFFF;
      for (int i = 0; i < n; i++) begin
        ids[i] = serial;
        scs[i] = SCORE_MIN;
        scd[i] = 0;
        serial = serial + 1;
      end
      count = 32'(n);
    endfunction

    function bit beats(int a, int b);
      if (scd[a] != scd[b]) return scd[a];
      return scs[a] > scs[b];
    endfunction

    // promote the top candidates or move to the next bracket
    function void close_batch();
      int unsigned keep_n, rank, w;
      bit keep[64];
      longint unsigned nb;
      keep_n = 32'(count / eff_eta());
      if (keep_n == 0 || rbud >= maxb_r) begin
        count = 0;
        rung = 0;
        brk = (brk + 1) % (top + 1);
        return;
      end
      for (int i = 0; i < count; i++) begin
        rank = 0;
        for (int j = 0; j < count; j++)
          if (j != i && (beats(j, i) || (j < i && !beats(i, j)))) rank++;
        keep[i] = rank < keep_n;
      end
      w = 0;
      for (int i = 0; i < count; i++) begin
        if (keep[i]) begin
          ids[w] = ids[i];
          scs[w] = scs[i];
          scd[w] = scd[i];
          w++;
        end
      end
      count = w;
      nb = rbud * eff_eta();
      if (nb > maxb_r) nb = maxb_r;
      rbud = nb & 16'hFFFF;
      rung = (rung + 1) & 15;
    endfunction

    function void note_request(logic [1:0] k, logic [31:0] id, logic [15:0] used,
                               logic signed [31:0] sc, logic be);
      listing_t r;
      int unsigned n;
      case (k)
        KIND_ASK: begin
          if (count == 0 && rung == 0) open_bracket();
          n = (count > MAX_LIST) ? MAX_LIST : count;
          for (int i = 0; i < n; i++) begin
            r.id = ids[i];
            r.budget = rbud[15:0];
            r.rung = rung[3:0];
            r.final_item = (i + 1 == n);
            r.best_score = best_sc;
            r.best_id = best_id;
            r.spent = spent[47:0];
            listings_q = {listings_q, r};
          end
        end
        KIND_TELL: begin
          spent = (spent + used > SPENT_MAX) ? SPENT_MAX : spent + used;
          if (sc > best_sc) begin
            best_sc = sc;
            best_id = id;
          end
          for (int i = 0; i < count; i++) begin
            if (ids[i] == id) begin
              scs[i] = sc;
              scd[i] = 1;
              break;
            end
          end
          if (be) close_batch();
        end
        KIND_RESET: clear();
        default: ;
      endcase
    endfunction

    function void cmp(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s mismatch: expected %0h actual %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_listing(listing_t got);
      listing_t e;
      if (listings_q.size() == 0) begin
        $error("unexpected listing id %0h", got.id);
        errors++;
        return;
      end
      e = listings_q.pop_front();
      cmp("out_id", e.id, got.id);
      cmp("out_budget", e.budget, got.budget);
      cmp("out_rung", e.rung, got.rung);
      cmp("out_final_item", e.final_item, got.final_item);
      cmp("out_best_score", e.best_score[31:0], got.best_score[31:0]);
      cmp("out_best_id", e.best_id, got.best_id);
      cmp("out_spent_total", e.spent, got.spent);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [KIND_W-1:0]         in_kind = '0;
  logic [ID_W-1:0]           in_candidate_id = '0;
  logic [BUD_W-1:0]          in_budget_used = '0;
  logic signed [SCORE_W-1:0] in_score = '0;
  logic                      in_batch_end = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [ID_W-1:0]           out_id;
  logic [BUD_W-1:0]          out_budget;
  logic [RUNG_W-1:0]         out_rung;
  logic                      out_final_item;
  logic signed [SCORE_W-1:0] out_best_score;
  logic [ID_W-1:0]           out_best_id;
  logic [SPENT_W-1:0]        out_spent_total;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  bracket_tracker tracker = new();
  bit  drv_high = 0;
  bit  hold_now = 0;
  int  burst_left = 0;
  int  sent = 0;
  int  idle_cycles = 0;

  successive_halving_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_candidate_id(in_candidate_id), .in_budget_used(in_budget_used),
    .in_score(in_score), .in_batch_end(in_batch_end),
    .out_valid(out_valid), .out_stall(out_stall), .out_id(out_id),
    .out_budget(out_budget), .out_rung(out_rung), .out_final_item(out_final_item),
    .out_best_score(out_best_score), .out_best_id(out_best_id),
    .out_spent_total(out_spent_total),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result check and watchdog
  always @(posedge clk) begin
    listing_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.id = out_id;
      got.budget = out_budget;
      got.rung = out_rung;
      got.final_item = out_final_item;
      got.best_score = out_best_score;
      got.best_id = out_best_id;
      got.spent = out_spent_total;
      tracker.check_listing(got);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else if (rst_n) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("successive_halving_scheduler_tb: FAIL");
      $finish;
    end
  end

  // receiver stall pattern, with a single long hold-off
  initial begin
    int mode;
    int span;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_now = 0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 96);
      end
      span--;
      out_stall <= (mode != 0) && ($urandom_range(0, 3) < mode);
    end
  end

  // one request, held until accepted
  task automatic send_req(input logic [1:0] k, input logic [31:0] id, input logic [15:0] used,
                          input logic signed [31:0] sc, input logic be);
    in_valid <= 1'b1;
    in_kind <= k;
    in_candidate_id <= id;
    in_budget_used <= used;
    in_score <= sc;
    in_batch_end <= be;
    drv_high = 1;
    do @(posedge clk); while (in_stall);
    tracker.note_request(k, id, used, sc, be);
    sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      drv_high = 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  // stop offering and wait for every expected listing
  task automatic drain();
    if (drv_high) begin
      in_valid <= 1'b0;
      drv_high = 0;
      @(posedge clk);
    end
    while (tracker.listings_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic set_regs(input logic [15:0] e, input logic [15:0] mn, input logic [15:0] mx);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_ETA, e);
    write_reg(CFG_MINB, mn);
    write_reg(CFG_MAXB, mx);
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_score();
    case ($urandom_range(0, 7))
      0: return SCORE_MIN;
      1: return 32'sh7FFF_FFFF;
      2, 3: return 32'($signed($urandom_range(0, 4)) - 2);
      default: return $urandom;
    endcase
  endfunction

  // ask, then score the listed candidates and close the batch
  task automatic run_round();
    int unsigned n;
    bit [31:0] cand[$];
    send_req(KIND_ASK, $urandom, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
    n = (tracker.count > MAX_LIST) ? MAX_LIST : tracker.count;
    cand.delete();
    for (int i = 0; i < n; i++) cand = {cand, tracker.ids[i]};
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: ;
        1: send_req(KIND_TELL, $urandom, 16'($urandom), pick_score(), 1'b0);
        2: send_req(KIND_NONE, $urandom, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
        3: send_req(KIND_ASK, $urandom, 16'($urandom), $urandom, 1'b0);
        default: ;
      endcase
      send_req(KIND_TELL, cand[i], 16'($urandom), pick_score(), i + 1 == n);
    end
    if ($urandom_range(0, 9) == 0) drain();
  endtask

  // unstructured requests, broken batches included
  task automatic run_noise();
    logic [1:0] k;
    k = ($urandom_range(0, 15) == 0) ? KIND_RESET : 2'($urandom_range(0, 3));
    if (k == KIND_RESET && $urandom_range(0, 1)) k = KIND_NONE;
    send_req(k, $urandom, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
  endtask

  typedef struct {
    logic [15:0] e;
    logic [15:0] mn;
    logic [15:0] mx;
    bit          do_reset;
  } setting_t;

  setting_t settings[7];

  initial begin
    int goal;
    settings[0] = '{16'd3, 16'd1, 16'd27, 1'b0};
    settings[1] = '{16'd2, 16'd1, 16'd65535, 1'b1};
    settings[2] = '{16'd8, 16'd1, 16'd65535, 1'b1};
    settings[3] = '{16'd0, 16'd0, 16'd0, 1'b1};
    settings[4] = '{16'd15, 16'd65535, 16'd65535, 1'b1};
    settings[5] = '{16'd4, 16'd100, 16'd50, 1'b1};
    settings[6] = '{16'd1, 16'd3, 16'd200, 1'b0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, unknown ids, unknown kind, reset request
    send_req(KIND_ASK, '0, '0, '0, 1'b0);
    send_req(KIND_TELL, tracker.ids[0], 16'hFFFF, 32'sh7FFF_FFFF, 1'b0);
    send_req(KIND_TELL, 32'hFFFF_FFFF, 16'h0000, SCORE_MIN, 1'b0);
    send_req(KIND_TELL, tracker.ids[1], 16'h8000, 32'sh7FFF_FFFF, 1'b0);
    send_req(KIND_TELL, tracker.ids[2], 16'h0001, -32'sd1, 1'b0);
    send_req(KIND_NONE, 32'hFFFF_FFFF, 16'hFFFF, -32'sd1, 1'b1);
    send_req(KIND_TELL, tracker.ids[2], 16'h0001, 32'sd5, 1'b1);
    send_req(KIND_ASK, '0, '0, '0, 1'b1);
    send_req(KIND_TELL, 32'h0, 16'h7FFF, SCORE_MIN, 1'b1);
    send_req(KIND_ASK, '0, '0, '0, 1'b0);
    send_req(KIND_TELL, tracker.ids[0], 16'h1234, 32'sh0001_0000, 1'b1);
    send_req(KIND_ASK, '0, '0, '0, 1'b0);
    send_req(KIND_RESET, 32'hFFFF_FFFF, 16'hFFFF, -32'sd1, 1'b1);
    send_req(KIND_ASK, '0, '0, '0, 1'b0);
    send_req(KIND_TELL, 32'h0, '0, '0, 1'b1);

    // random phases over several register settings
    for (int p = 0; p < 7; p++) begin
      set_regs(settings[p].e, settings[p].mn, settings[p].mx);
      if (settings[p].do_reset) send_req(KIND_RESET, '0, '0, '0, 1'b0);
      goal = ITEM_TARGET * (p + 1) / 7;
      if (p == 2) hold_now = 1;
      while (sent < goal) begin
        if ($urandom_range(0, 4) == 0) run_noise();
        else run_round();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.listings_q.size() == 0) begin
      $display("successive_halving_scheduler_tb: PASS");
    end else begin
      $display("successive_halving_scheduler_tb: FAIL");
    end
    $finish;
  end

endmodule
